### src/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsv2rgb_pkg;

  localparam int NSTAGE = 6;

  localparam int HUE_FULL = 5760;
  localparam logic [16:0] HUE_BIAS = 17'(HUE_FULL - (32768 % HUE_FULL));
  localparam logic [9:0] HUE_SECTOR = 10'd960;
  localparam logic [6:0] SEC_RECIP = 7'd68;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [14:0] PCT_FULL = 15'd25600;
  localparam logic [3:0] DIV15 = 4'd15;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

### src/hsv2rgb_ctrl.sv
// Valid and load control for the converter pipeline.
// Depends on hsv2rgb_pkg for the stage count.
module hsv2rgb_ctrl
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  input  logic              m_ready,
  output logic [NSTAGE-1:0] load,
  output logic              s_ready,
  output logic              m_valid
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;

  always_comb begin
    load[NSTAGE-1] = ~valid[NSTAGE-1] | m_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = ~valid[k] | load[k+1];
    end
  end

  assign valid_next = {valid[NSTAGE-2:0], s_valid};
  assign s_ready    = load[0];
  assign m_valid    = valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (load[k]) begin
          valid[k] <= valid_next[k];
        end
      end
    end
  end

endmodule

### src/hsv2rgb_front.sv
// Front stages: hue wrap and sector split, chroma and offset.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [1:0]           load,
  input  logic [15:0]          hue_sixteenths,
  input  logic [16:0]          saturation_q16,
  input  logic [16:0]          brightness_q16,
  output logic                 rej,
  output sector_t              sector,
  output logic [9:0]           grad,
  output logic [FRAC_BITS:0]   cq,
  output logic [FRAC_BITS:0]   mq
);

  localparam int FW = FRAC_BITS + 1;

  logic [16:0] biased;
  logic [16:0] n_in;
  logic [23:0] q0_prod;

  logic        a_rej;
  logic [16:0] a_n;
  logic [6:0]  a_q0;
  logic [33:0] a_prod;
  logic [16:0] a_v;

  logic [16:0] rem;
  logic        hi;
  logic [6:0]  q;
  logic [9:0]  f;
  logic [11:0] q43;
  logic [6:0]  q6;
  logic [2:0]  sec;
  logic [FW-1:0] cq_c;
  logic [FW-1:0] vq_c;
  logic [FRAC_BITS+16:0] v_wide;

  assign biased  = {1'b0, ~hue_sixteenths[15], hue_sixteenths[14:0]};
  assign n_in    = biased + HUE_BIAS;
  assign q0_prod = 24'(n_in) * 24'(SEC_RECIP);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a_rej  <= (saturation_q16 > ONE_Q16) || (brightness_q16 > ONE_Q16);
      a_n    <= n_in;
      a_q0   <= q0_prod[22:16];
      a_prod <= 34'(saturation_q16) * 34'(brightness_q16);
      a_v    <= brightness_q16;
    end
  end

  assign rem    = a_n - 17'(a_q0) * 17'(HUE_SECTOR);
  assign hi     = rem >= 17'(HUE_SECTOR);
  assign q      = a_q0 + 7'(hi);
  assign f      = hi ? 10'(rem - 17'(HUE_SECTOR)) : 10'(rem);
  assign q43    = 12'(q) * 12'd43;
  assign q6     = 7'(q43[11:8]);
  assign sec    = 3'(q - q6 * 7'd6);
  assign cq_c   = FW'(a_prod >> (32 - FRAC_BITS));
  assign v_wide = {a_v, {FRAC_BITS{1'b0}}};
  assign vq_c   = FW'(v_wide >> 16);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      rej    <= a_rej;
      sector <= sector_t'(sec);
      grad   <= sec[0] ? HUE_SECTOR - f : f;
      cq     <= cq_c;
      mq     <= vq_c - cq_c;
    end
  end

endmodule

### src/hsv2rgb_xterm.sv
// Secondary term x = c*g/960 and per-sector channel arrangement.
// Depends on hsv2rgb_pkg.
module hsv2rgb_xterm
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [2:0]           load,
  input  logic                 rej_in,
  input  sector_t              sector,
  input  logic [9:0]           grad,
  input  logic [FRAC_BITS:0]   cq,
  input  logic [FRAC_BITS:0]   mq,
  output logic                 rej,
  output logic [FRAC_BITS:0]   sum_r,
  output logic [FRAC_BITS:0]   sum_g,
  output logic [FRAC_BITS:0]   sum_b
);

  localparam int FW = FRAC_BITS + 1;
  localparam int W  = FRAC_BITS + 5;
  localparam logic [W-1:0] K = W'((64'(1) << W) / 15);

  logic          c_rej;
  sector_t       c_sec;
  logic [FW+9:0] c_cg;
  logic [FW-1:0] c_cq;
  logic [FW-1:0] c_mq;

  logic [2*W-1:0] recip_prod;

  logic          d_rej;
  sector_t       d_sec;
  logic [W-1:0]  d_n6;
  logic [FW-1:0] d_x0;
  logic [FW-1:0] d_cq;
  logic [FW-1:0] d_mq;

  logic [W-1:0]  rem;
  logic [FW-1:0] x;
  logic [FW-1:0] pr;
  logic [FW-1:0] pg;
  logic [FW-1:0] pb;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      c_rej <= rej_in;
      c_sec <= sector;
      c_cg  <= (FW+10)'(cq) * (FW+10)'(grad);
      c_cq  <= cq;
      c_mq  <= mq;
    end
  end

  assign recip_prod = (2*W)'(c_cg[FW+9:6]) * (2*W)'(K);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      d_rej <= c_rej;
      d_sec <= c_sec;
      d_n6  <= c_cg[FW+9:6];
      d_x0  <= FW'(recip_prod >> W);
      d_cq  <= c_cq;
      d_mq  <= c_mq;
    end
  end

  assign rem = d_n6 - W'(d_x0) * W'(DIV15);
  assign x   = (rem >= W'(DIV15)) ? d_x0 + FW'(1) : d_x0;

  always_comb begin
    unique case (d_sec)
      SEC_RED_YEL: begin pr = d_cq; pg = x;    pb = '0;   end
      SEC_YEL_GRN: begin pr = x;    pg = d_cq; pb = '0;   end
      SEC_GRN_CYN: begin pr = '0;   pg = d_cq; pb = x;    end
      SEC_CYN_BLU: begin pr = '0;   pg = x;    pb = d_cq; end
      SEC_BLU_MAG: begin pr = x;    pg = '0;   pb = d_cq; end
      default:     begin pr = d_cq; pg = '0;   pb = x;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      rej   <= d_rej;
      sum_r <= pr + d_mq;
      sum_g <= pg + d_mq;
      sum_b <= pb + d_mq;
    end
  end

endmodule

### src/hsv2rgb_scale.sv
// Output stage: scale Q.F channel levels to percent with 8 fraction bits.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 rej_in,
  input  logic [FRAC_BITS:0]   sum_r,
  input  logic [FRAC_BITS:0]   sum_g,
  input  logic [FRAC_BITS:0]   sum_b,
  output logic [14:0]          red_pct,
  output logic [14:0]          green_pct,
  output logic [14:0]          blue_pct,
  output logic                 rejected
);

  localparam int PW = FRAC_BITS + 16;

  logic [PW-1:0] pr;
  logic [PW-1:0] pg;
  logic [PW-1:0] pb;

  assign pr = PW'(sum_r) * PW'(PCT_FULL);
  assign pg = PW'(sum_g) * PW'(PCT_FULL);
  assign pb = PW'(sum_b) * PW'(PCT_FULL);

  always_ff @(posedge clk) begin
    if (load) begin
      rejected  <= rej_in;
      red_pct   <= rej_in ? '0 : pr[FRAC_BITS +: 15];
      green_pct <= rej_in ? '0 : pg[FRAC_BITS +: 15];
      blue_pct  <= rej_in ? '0 : pb[FRAC_BITS +: 15];
    end
  end

endmodule

### src/hsv_to_rgb_converter.sv
// Channel   Dir  Signals                      Beat contents
// s_*       in   s_tvalid s_tready s_tdata    hue, saturation, brightness
// m_*       out  m_tvalid m_tready m_tdata    red, green, blue percent
//                m_tuser                      rejected flag
//
// One beat per cycle sustained while m_tready is high, with one register per stage.
// The six stages are wrap/sector with the s*v multiply, chroma and offset, c*g,
// reciprocal multiply for /960, correction and arrangement, percent scaling.
// Synchronous reset clears only the valid bits; no clearing pass.
// A stall on m_tready fills empty stages first; s_tready drops only when all are full.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // hue_sixteenths[15:0], saturation_q16[32:16], brightness_q16[49:33]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red_pct[14:0], green_pct[29:15], blue_pct[44:30]
  output logic [0:0]  m_tuser    // rejected[0]
);

  logic [NSTAGE-1:0] load;

  logic               f_rej;
  sector_t            f_sec;
  logic [9:0]         f_grad;
  logic [FRAC_BITS:0] f_cq;
  logic [FRAC_BITS:0] f_mq;

  logic               x_rej;
  logic [FRAC_BITS:0] x_r;
  logic [FRAC_BITS:0] x_g;
  logic [FRAC_BITS:0] x_b;

  logic [14:0] red_pct;
  logic [14:0] green_pct;
  logic [14:0] blue_pct;
  logic        rejected;

  hsv2rgb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .m_ready (m_tready),
    .load    (load),
    .s_ready (s_tready),
    .m_valid (m_tvalid)
  );

  hsv2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .load           (load[1:0]),
    .hue_sixteenths (s_tdata[15:0]),
    .saturation_q16 (s_tdata[32:16]),
    .brightness_q16 (s_tdata[49:33]),
    .rej            (f_rej),
    .sector         (f_sec),
    .grad           (f_grad),
    .cq             (f_cq),
    .mq             (f_mq)
  );

  hsv2rgb_xterm #(.FRAC_BITS(FRAC_BITS)) u_xterm (
    .clk    (clk),
    .load   (load[4:2]),
    .rej_in (f_rej),
    .sector (f_sec),
    .grad   (f_grad),
    .cq     (f_cq),
    .mq     (f_mq),
    .rej    (x_rej),
    .sum_r  (x_r),
    .sum_g  (x_g),
    .sum_b  (x_b)
  );

  hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk       (clk),
    .load      (load[5]),
    .rej_in    (x_rej),
    .sum_r     (x_r),
    .sum_g     (x_g),
    .sum_b     (x_b),
    .red_pct   (red_pct),
    .green_pct (green_pct),
    .blue_pct  (blue_pct),
    .rejected  (rejected)
  );

  assign m_tdata = {3'b000, blue_pct, green_pct, red_pct};
  assign m_tuser = rejected;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && rejected |-> red_pct == '0 && green_pct == '0 && blue_pct == '0)
    else $error("rejected beat carries nonzero color");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> red_pct <= PCT_FULL && green_pct <= PCT_FULL && blue_pct <= PCT_FULL)
    else $error("channel above full scale");

  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with an empty slot in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
